### sv/shortened_hamming_codec_macros.svh
// Assertion macros used by the shortened Hamming codec checker.
`ifndef SHORTENED_HAMMING_CODEC_MACROS_SVH
`define SHORTENED_HAMMING_CODEC_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that must also hold during reset.
`define SHC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/shc_pkg.sv
// Shared constants, widths and position helpers for the shortened Hamming codec.
`default_nettype none

package shc_pkg;

  // Field widths.
  localparam int DATA_W = 64;
  localparam int LEN_W = 6;

  // Largest message length the frame can carry (six parity bits).
  localparam int MAX_MESSAGE_BITS = 57;

  // Shortest frame: one message bit and two parity bits.
  localparam logic [LEN_W-1:0] MIN_FRAME_BITS = 6'd3;

  // Message length after reset.
  localparam logic [LEN_W-1:0] MSG_BITS_RESET = 6'd4;

  // Register map.
  localparam int PADDR_W = 2;
  localparam logic [PADDR_W-1:0] ADDR_MSG_BITS = 2'd0;

  // Command codes.
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // One-based frame position of message bit j: the j-th position that is not
  // a power of two.
  function automatic logic [LEN_W-1:0] data_pos(input int unsigned j);
    int unsigned cnt;
    logic [LEN_W-1:0] pos;
    cnt = 0;
    pos = '0;
    for (int unsigned p = 1; p < 64; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == j) begin
          pos = LEN_W'(p);
        end
        cnt++;
      end
    end
    return pos;
  endfunction

  // Frame length for a message length already clamped to its legal range.
  function automatic logic [LEN_W-1:0] frame_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    if (len <= 6'd1) begin
      r = 6'd2;
    end else if (len <= 6'd4) begin
      r = 6'd3;
    end else if (len <= 6'd11) begin
      r = 6'd4;
    end else if (len <= 6'd26) begin
      r = 6'd5;
    end else begin
      r = 6'd6;
    end
    return len + r;
  endfunction

endpackage

`default_nettype wire

### sv/shortened_hamming_codec.sv
// Top level of the shortened Hamming single-error-correcting encoder/decoder.
`default_nettype none

// Usage:
//   A command beat is taken at a rising edge where start is high and busy is
//   low. busy is always low, so a new beat may be issued in every cycle.
//   command selects encode (message word in, frame out) or decode (frame
//   word in, corrected message out with the syndrome and an out-of-range flag).
//   Each beat produces exactly one result beat, shown on the result ports for
//   one cycle with done high. The receiver cannot stall, so results must be
//   taken in the cycle they appear.
//   The beat is captured in an input register, the XOR trees and bit
//   placement run on that register in the next cycle, and the result
//   register drives the outputs. Throughput is one beat per cycle.
//   The message length register (APB address 0) sets the frame length; the user
//   must write it only while no beat is in flight; the block does not enforce
//   this. Values of 0 act as 1, above 57 as 57; six bits are kept and read back.
//   Synchronous reset drops any beat in flight and sets the message length to 4.
module shortened_hamming_codec (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Command channel.
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         command,
  input  wire logic [shc_pkg::DATA_W-1:0]   data_word,
  // Result channel.
  output logic                              done,
  output logic [shc_pkg::DATA_W-1:0]        result_word,
  output logic [shc_pkg::LEN_W-1:0]         frame_bits,
  output logic [shc_pkg::LEN_W-1:0]         error_position,
  output logic                              out_of_range,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [shc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import shc_pkg::*;

  // Configuration register.
  logic [LEN_W-1:0]  msg_bits;

  // Input register stage.
  logic              in_valid;
  logic              in_command;
  logic [DATA_W-1:0] in_word;

  // Working signals.
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  n_len;
  logic [DATA_W-1:0] enc_frame;
  logic [LEN_W-1:0]  enc_acc;
  logic [DATA_W-1:0] dec_frame;
  logic [LEN_W-1:0]  syndrome;
  logic              flip_en;
  logic              syn_beyond;
  logic [DATA_W-1:0] fixed_frame;
  logic [DATA_W-1:0] dec_msg;
  logic              accept;

  // The block never holds off a command beat.
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // Register write and read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_bits <= MSG_BITS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MSG_BITS) begin
      msg_bits <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_MSG_BITS) begin
      prdata[LEN_W-1:0] = msg_bits;
    end
  end

  // Clamp the configured length and derive the frame length.
  always_comb begin
    len_eff = msg_bits;
    if (msg_bits == '0) begin
      len_eff = 6'd1;
    end else if (msg_bits > LEN_W'(MAX_MESSAGE_BITS)) begin
      len_eff = LEN_W'(MAX_MESSAGE_BITS);
    end
  end

  assign n_len = frame_len(len_eff);

  // Capture the command beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    if (accept) begin
      in_command <= command;
      in_word    <= data_word;
    end
  end

  // Encode: scatter message bits to data positions, then set parity bits from
  // the XOR of all positions that hold a one.
  always_comb begin
    enc_frame = '0;
    enc_acc   = '0;
    for (int j = 0; j < MAX_MESSAGE_BITS; j++) begin
      if (LEN_W'(j) < len_eff && in_word[j]) begin
        enc_frame[data_pos(j) - 6'd1] = 1'b1;
        enc_acc = enc_acc ^ data_pos(j);
      end
    end
    for (int i = 0; i < LEN_W; i++) begin
      enc_frame[(1 << i) - 1] = enc_acc[i];
    end
  end

  // Decode: drop bits beyond the frame and form the syndrome.
  always_comb begin
    dec_frame = '0;
    syndrome  = '0;
    for (int k = 0; k < DATA_W - 1; k++) begin
      dec_frame[k] = in_word[k] && (LEN_W'(k) < n_len);
      if (dec_frame[k]) begin
        syndrome = syndrome ^ LEN_W'(k + 1);
      end
    end
  end

  // Correct the indicated bit when it lies inside the frame.
  assign syn_beyond  = (syndrome != '0) && (syndrome > n_len);
  assign flip_en     = (syndrome != '0) && !syn_beyond;
  assign fixed_frame = dec_frame ^ (DATA_W'(flip_en) << (syndrome - 6'd1));

  // Gather the message bits back from their data positions.
  always_comb begin
    dec_msg = '0;
    for (int j = 0; j < MAX_MESSAGE_BITS; j++) begin
      dec_msg[j] = fixed_frame[data_pos(j) - 6'd1] && (LEN_W'(j) < len_eff);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      frame_bits <= n_len;
      if (in_command == CMD_DECODE) begin
        result_word    <= dec_msg;
        error_position <= syndrome;
        out_of_range   <= syn_beyond;
      end else begin
        result_word    <= enc_frame;
        error_position <= '0;
        out_of_range   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### sv/shc_checker.sv
// Port-level checker for the shortened Hamming codec, bound to the top level.
`default_nettype none

`include "shortened_hamming_codec_macros.svh"

module shc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic [shc_pkg::LEN_W-1:0]  frame_bits,
  input wire logic [shc_pkg::LEN_W-1:0]  error_position,
  input wire logic                       out_of_range
);

  import shc_pkg::*;

  // Every accepted beat yields its result through the input and result registers.
  `SHC_ASSERT(a_latency, start && !busy |-> ##2 done, "accepted beat gave no result")

  // No result appears without an earlier accepted beat.
  `SHC_ASSERT(a_no_spurious, done |-> $past(start && !busy, 2), "result without a beat")

  // The out-of-range flag means a nonzero syndrome beyond the frame.
  `SHC_ASSERT(a_range_flag, done && out_of_range |-> error_position > frame_bits,
    "out_of_range set for a syndrome inside the frame")

  // A reported frame length is never below the shortest frame.
  `SHC_ASSERT(a_min_frame, done |-> frame_bits >= MIN_FRAME_BITS,
    "frame length below minimum")

  // Commands are never held off.
  `SHC_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

bind shortened_hamming_codec shc_checker u_shc_checker (.*);

`default_nettype wire
